// ===== sv/rrf_pkg.sv =====
// ----------------------------------------------------------------------------
// rrf_pkg
// Types and constants shared by the rectangle raster fill block.
// ----------------------------------------------------------------------------
`default_nettype none

package rrf_pkg;

  localparam int unsigned MAX_SIDE  = 256;
  localparam int unsigned FRAC_BITS = 8;
  localparam int unsigned SIDE_W    = $clog2(MAX_SIDE);
  localparam int unsigned ZONE_W    = SIDE_W + 1;
  localparam int unsigned ADDR_W    = 2 * SIDE_W;
  localparam int unsigned COORD_W   = 20;
  localparam int unsigned CODE_W    = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 9;
  // working width of the scan compares: sum of two coordinates plus sign
  localparam int unsigned POS_W     = (COORD_W > SIDE_W + FRAC_BITS + 1) ?
                                      COORD_W + 2 : SIDE_W + FRAC_BITS + 2;

  localparam logic [ZONE_W-1:0] ZONE_MAX       = ZONE_W'(MAX_SIDE);
  localparam logic [ZONE_W-1:0] ZONE_W_RESET   = ZONE_W'(1);
  localparam logic [ZONE_W-1:0] ZONE_H_RESET   = ZONE_W'(1);
  localparam logic [CODE_W-1:0] BG_CODE_RESET  = CODE_W'(32);

  typedef enum logic [1:0] {
    CMD_FILL    = 2'd0,
    CMD_OUTLINE = 2'd1,
    CMD_READ    = 2'd2,
    CMD_CLEAR   = 2'd3
  } rrf_cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ZONE_WIDTH  = 2'd0,
    CFG_ZONE_HEIGHT = 2'd1,
    CFG_BG_CODE     = 2'd2,
    CFG_UNUSED      = 2'd3
  } rrf_cfg_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SCAN   = 2'd1,
    ST_READ   = 2'd2,
    ST_FINISH = 2'd3
  } rrf_state_e;

  typedef struct packed {
    logic [1:0]                cmd;
    logic signed [COORD_W-1:0] rect_left;
    logic signed [COORD_W-1:0] rect_top;
    logic signed [COORD_W-1:0] rect_span_x;
    logic signed [COORD_W-1:0] rect_span_y;
    logic [CODE_W-1:0]         paint_code;
    logic [SIDE_W-1:0]         read_col;
    logic [SIDE_W-1:0]         read_row;
  } rrf_in_t;

  typedef struct packed {
    logic [CODE_W-1:0] pixel_code;
    logic              status;
  } rrf_out_t;

  // scan launch request from the control fsm
  typedef struct packed {
    logic                      start;
    logic                      clear;
    logic                      outline;
    logic [CODE_W-1:0]         code;
    logic signed [COORD_W-1:0] left;
    logic signed [COORD_W-1:0] top;
    logic signed [COORD_W-1:0] span_x;
    logic signed [COORD_W-1:0] span_y;
    logic [ZONE_W-1:0]         zone_w;
    logic [ZONE_W-1:0]         zone_h;
  } rrf_scan_req_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [CODE_W-1:0] data;
  } rrf_wr_t;

endpackage

`default_nettype wire

// ===== sv/rrf_frame_ram.sv =====
// ----------------------------------------------------------------------------
// rrf_frame_ram
// Pixel store, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rrf_frame_ram (
  input  wire logic                         clk_i,
  input  wire rrf_pkg::rrf_wr_t             wr_i,
  input  wire logic                         rd_en_i,
  input  wire logic [rrf_pkg::ADDR_W-1:0]   rd_addr_i,
  output logic      [rrf_pkg::CODE_W-1:0]   rd_data_o
);

  logic [rrf_pkg::CODE_W-1:0] mem [2**rrf_pkg::ADDR_W];
  logic [rrf_pkg::CODE_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== sv/rrf_scan.sv =====
// ----------------------------------------------------------------------------
// rrf_scan
// Pixel walker: visits every pixel of the zone once, tests it against the
// rectangle with one shared compare unit and issues the store write.
// ----------------------------------------------------------------------------
`default_nettype none

module rrf_scan (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire rrf_pkg::rrf_scan_req_t req_i,
  output rrf_pkg::rrf_wr_t            wr_o,
  output logic                        done_o
);

  localparam int unsigned PW = rrf_pkg::POS_W;
  localparam int unsigned SW = rrf_pkg::SIDE_W;
  localparam int unsigned FB = rrf_pkg::FRAC_BITS;
  localparam logic signed [PW-1:0] ONE = PW'(2 ** FB);

  logic                          busy_q;
  logic [SW-1:0]                 col_q, row_q;
  logic                          clear_q, outline_q;
  logic [rrf_pkg::CODE_W-1:0]    code_q;
  logic signed [PW-1:0]          left_q, top_q, right_q, bottom_q;
  logic [rrf_pkg::ZONE_W-1:0]    zw_q, zh_q;

  logic signed [PW-1:0] left_ext, top_ext, spx_ext, spy_ext;
  logic signed [PW-1:0] px, py;
  logic signed [PW-1:0] dx_l, dx_r, dy_t, dy_b;
  logic                 in_x, in_y, near_edge, hit;
  logic                 last_col, last_row;

  assign left_ext = PW'(req_i.left);
  assign top_ext  = PW'(req_i.top);
  assign spx_ext  = PW'(req_i.span_x);
  assign spy_ext  = PW'(req_i.span_y);

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      clear_q   <= req_i.clear;
      outline_q <= req_i.outline;
      code_q    <= req_i.code;
      left_q    <= left_ext;
      top_q     <= top_ext;
      right_q   <= left_ext + spx_ext;
      bottom_q  <= top_ext + spy_ext;
      zw_q      <= req_i.zone_w;
      zh_q      <= req_i.zone_h;
    end
  end

  // pixel position in fixed point
  assign px = $signed({{(PW-SW-FB){1'b0}}, col_q, {FB{1'b0}}});
  assign py = $signed({{(PW-SW-FB){1'b0}}, row_q, {FB{1'b0}}});

  assign dx_l = px - left_q;
  assign dx_r = right_q - px;
  assign dy_t = py - top_q;
  assign dy_b = bottom_q - py;

  assign in_x      = !dx_l[PW-1] && !dx_r[PW-1];
  assign in_y      = !dy_t[PW-1] && !dy_b[PW-1];
  assign near_edge = (dx_l < ONE) || (dx_r < ONE) || (dy_t < ONE) || (dy_b < ONE);
  assign hit       = clear_q || (in_x && in_y && (!outline_q || near_edge));

  assign last_col = ({1'b0, col_q} == zw_q - rrf_pkg::ZONE_W'(1));
  assign last_row = ({1'b0, row_q} == zh_q - rrf_pkg::ZONE_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      col_q  <= '0;
      row_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      col_q  <= '0;
      row_q  <= '0;
    end else if (busy_q) begin
      if (last_col) begin
        col_q <= '0;
        row_q <= row_q + SW'(1);
        if (last_row) begin
          busy_q <= 1'b0;
        end
      end else begin
        col_q <= col_q + SW'(1);
      end
    end
  end

  assign wr_o.en   = busy_q && hit;
  assign wr_o.addr = {row_q, col_q};
  assign wr_o.data = code_q;
  assign done_o    = busy_q && last_col && last_row;

endmodule

`default_nettype wire

// ===== sv/rectangle_raster_fill.sv =====
// ----------------------------------------------------------------------------
// rectangle_raster_fill
// Character framebuffer that clears, fills and outlines axis-aligned
// rectangles and reads back single pixels.
// ----------------------------------------------------------------------------
//  port group   direction  handshake              word
//  in_*         in         in_valid_i/in_stall_o   rrf_in_t
//  out_*        out        out_valid_o/out_stall_i rrf_out_t
//  cfg_*        in         cfg_valid_i/cfg_ready_o index + 9-bit data
//
//  a draw or clear walks the zone one pixel a cycle, a rate set by the
//  pixel walker and the single store write port; a read passes through
//  the read and finish states, a rejected shape goes straight to finish
//  the store is not cleared by reset; pixels read before any write are undefined
//  a finished word waits in the output register while the next word is taken
// ----------------------------------------------------------------------------
`default_nettype none

module rectangle_raster_fill (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire rrf_pkg::rrf_in_t                  in_word_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output rrf_pkg::rrf_out_t                      out_word_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [rrf_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [rrf_pkg::CFG_DAT_W-1:0]     cfg_data_i
);

  rrf_pkg::rrf_state_e       state_q, state_d;
  logic [rrf_pkg::ZONE_W-1:0] zone_w_q, zone_h_q, zw, zh;
  logic [rrf_pkg::CODE_W-1:0] bg_q;
  rrf_pkg::rrf_in_t          item_q;
  logic                      status_q, status_d;
  logic                      out_valid_q;
  rrf_pkg::rrf_out_t         out_word_q, out_word_d;
  logic                      out_load;

  logic                      accept, zone_empty, reject, is_draw;
  rrf_pkg::rrf_scan_req_t    scan_req;
  rrf_pkg::rrf_wr_t          wr;
  logic                      scan_done;
  logic                      rd_en;
  logic [rrf_pkg::CODE_W-1:0] rd_data;
  logic                      read_hit;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_w_q <= rrf_pkg::ZONE_W_RESET;
      zone_h_q <= rrf_pkg::ZONE_H_RESET;
      bg_q     <= rrf_pkg::BG_CODE_RESET;
    end else if (cfg_valid_i) begin
      unique case (rrf_pkg::rrf_cfg_e'(cfg_index_i))
        rrf_pkg::CFG_ZONE_WIDTH:  zone_w_q <= cfg_data_i;
        rrf_pkg::CFG_ZONE_HEIGHT: zone_h_q <= cfg_data_i;
        rrf_pkg::CFG_BG_CODE:     bg_q     <= cfg_data_i[rrf_pkg::CODE_W-1:0];
        default: ;
      endcase
    end
  end

  assign zw = (zone_w_q > rrf_pkg::ZONE_MAX) ? rrf_pkg::ZONE_MAX : zone_w_q;
  assign zh = (zone_h_q > rrf_pkg::ZONE_MAX) ? rrf_pkg::ZONE_MAX : zone_h_q;
  assign zone_empty = (zw == '0) || (zh == '0);

  // command decode
  assign accept  = in_valid_i && !in_stall_o;
  assign is_draw = (in_word_i.cmd == rrf_pkg::CMD_FILL) ||
                   (in_word_i.cmd == rrf_pkg::CMD_OUTLINE);
  assign reject  = is_draw && ((in_word_i.rect_span_x <= 0) ||
                               (in_word_i.rect_span_y <= 0));

  assign scan_req.clear   = (in_word_i.cmd == rrf_pkg::CMD_CLEAR);
  assign scan_req.outline = (in_word_i.cmd == rrf_pkg::CMD_OUTLINE);
  assign scan_req.code    = scan_req.clear ? bg_q : in_word_i.paint_code;
  assign scan_req.left    = in_word_i.rect_left;
  assign scan_req.top     = in_word_i.rect_top;
  assign scan_req.span_x  = in_word_i.rect_span_x;
  assign scan_req.span_y  = in_word_i.rect_span_y;
  assign scan_req.zone_w  = zw;
  assign scan_req.zone_h  = zh;
  assign scan_req.start   = accept && (in_word_i.cmd != rrf_pkg::CMD_READ) &&
                            !reject && !zone_empty;

  assign read_hit = (item_q.cmd == rrf_pkg::CMD_READ) &&
                    ({1'b0, item_q.read_col} < zw) && ({1'b0, item_q.read_row} < zh);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rrf_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    status_d   = status_q;
    rd_en      = 1'b0;
    out_load   = 1'b0;
    out_word_d = out_word_q;
    unique case (state_q)
      rrf_pkg::ST_IDLE: begin
        if (accept) begin
          status_d = reject;
          if (in_word_i.cmd == rrf_pkg::CMD_READ) begin
            state_d = rrf_pkg::ST_READ;
          end else if (scan_req.start) begin
            state_d = rrf_pkg::ST_SCAN;
          end else begin
            state_d = rrf_pkg::ST_FINISH;
          end
        end
      end
      rrf_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_d = rrf_pkg::ST_FINISH;
        end
      end
      rrf_pkg::ST_READ: begin
        rd_en   = 1'b1;
        state_d = rrf_pkg::ST_FINISH;
      end
      rrf_pkg::ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load              = 1'b1;
          out_word_d.pixel_code = read_hit ? rd_data : '0;
          out_word_d.status     = status_q;
          state_d               = rrf_pkg::ST_IDLE;
        end
      end
      default: state_d = rrf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_word_i;
    end
    status_q <= status_d;
    if (out_load) begin
      out_word_q <= out_word_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign in_stall_o  = (state_q != rrf_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  rrf_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (scan_req),
    .wr_o   (wr),
    .done_o (scan_done)
  );

  rrf_frame_ram u_ram (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_en_i   (rd_en),
    .rd_addr_i ({item_q.read_row, item_q.read_col}),
    .rd_data_o (rd_data)
  );

  // store writes only while a scan is running
  a_write_in_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.en |-> state_q == rrf_pkg::ST_SCAN)
    else $error("store write outside scan");

  a_done_in_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_done |-> state_q == rrf_pkg::ST_SCAN)
    else $error("scan finished outside scan state");

  a_finish_emits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rrf_pkg::ST_FINISH && !(out_valid_q && out_stall_i)) |=>
      (out_valid_q && state_q == rrf_pkg::ST_IDLE))
    else $error("finished word not presented");

  a_reject_no_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.status) |-> out_word_o.pixel_code == '0)
    else $error("rejected word carries a pixel code");

endmodule

`default_nettype wire

// ===== test/rectangle_raster_fill_tb.sv =====
// ----------------------------------------------------------------------------
// rectangle_raster_fill_tb
// Self-checking bench for the rectangle raster fill block. A queue-fed driver
// sends command words, and each accepted word is run through a behavioral
// framebuffer that predicts the result word. A monitor checks every result
// against the oldest prediction. The zone and background registers go
// through several settings, the extremes among them, and both sides idle and
// stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module rectangle_raster_fill_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IDLE_LIMIT = 400000;

  logic                          clk_i;
  logic                          rst_ni      = 1'b0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_stall_o;
  rrf_pkg::rrf_in_t              in_word_i   = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  rrf_pkg::rrf_out_t             out_word_o;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [rrf_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [rrf_pkg::CFG_DAT_W-1:0] cfg_data_i  = '0;

  // framebuffer image and register copies
  logic [rrf_pkg::CODE_W-1:0] image_q [rrf_pkg::MAX_SIDE*rrf_pkg::MAX_SIDE];
  logic [rrf_pkg::ZONE_W-1:0] zone_w_q = rrf_pkg::ZONE_W_RESET;
  logic [rrf_pkg::ZONE_W-1:0] zone_h_q = rrf_pkg::ZONE_H_RESET;
  logic [rrf_pkg::CODE_W-1:0] bg_q     = rrf_pkg::BG_CODE_RESET;

  rrf_pkg::rrf_in_t  pending_words [$];
  rrf_pkg::rrf_out_t expected_words [$];
  rrf_pkg::rrf_out_t want_word;
  int unsigned       send_hold, send_quiet, recv_hold, recv_quiet, recv_pick;
  int unsigned       idle_cycles;
  int unsigned       mismatch_count;

  rectangle_raster_fill dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap(inout int unsigned quiet);
    int unsigned r;
    if (quiet != 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      quiet = $urandom_range(20, 80);
      return 0;
    end
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic rrf_pkg::rrf_out_t paint_and_report(rrf_pkg::rrf_in_t w);
    rrf_pkg::rrf_out_t res;
    int unsigned       zw, zh, row, col;
    longint            lft, y0, rgt, bot, px, py, one;
    logic              on_rim;
    res = '0;
    one = longint'(1) << rrf_pkg::FRAC_BITS;
    zw  = (zone_w_q > rrf_pkg::MAX_SIDE) ? rrf_pkg::MAX_SIDE : zone_w_q;
    zh  = (zone_h_q > rrf_pkg::MAX_SIDE) ? rrf_pkg::MAX_SIDE : zone_h_q;
    case (w.cmd)
      rrf_pkg::CMD_READ: begin
        if (w.read_col < zw && w.read_row < zh) begin
          res.pixel_code = image_q[w.read_row * rrf_pkg::MAX_SIDE + w.read_col];
        end
      end
      rrf_pkg::CMD_CLEAR: begin
        for (row = 0; row < zh; row++) begin
          for (col = 0; col < zw; col++) begin
            image_q[row * rrf_pkg::MAX_SIDE + col] = bg_q;
          end
        end
      end
      default: begin
        lft = $signed(w.rect_left);
        y0  = $signed(w.rect_top);
        rgt = lft + $signed(w.rect_span_x);
        bot = y0 + $signed(w.rect_span_y);
        if ($signed(w.rect_span_x) <= 0 || $signed(w.rect_span_y) <= 0) begin
          res.status = 1'b1;
        end else begin
          for (row = 0; row < zh; row++) begin
            py = longint'(row) * one;
            if (py < y0 || py > bot) continue;
            for (col = 0; col < zw; col++) begin
              px = longint'(col) * one;
              if (px < lft || px > rgt) continue;
              on_rim = (px - lft < one) || (rgt - px < one) ||
                       (py - y0 < one) || (bot - py < one);
              if (w.cmd == rrf_pkg::CMD_FILL || on_rim) begin
                image_q[row * rrf_pkg::MAX_SIDE + col] = w.paint_code;
              end
            end
          end
        end
      end
    endcase
    return res;
  endfunction

  function automatic rrf_pkg::rrf_in_t noise_word();
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    return raw[$bits(rrf_pkg::rrf_in_t)-1:0];
  endfunction

  function automatic rrf_pkg::rrf_in_t shape_word(rrf_pkg::rrf_cmd_e c, int l, int t,
                                                  int sx, int sy, int unsigned code);
    rrf_pkg::rrf_in_t w;
    w             = noise_word();
    w.cmd         = c;
    w.rect_left   = rrf_pkg::COORD_W'(l);
    w.rect_top    = rrf_pkg::COORD_W'(t);
    w.rect_span_x = rrf_pkg::COORD_W'(sx);
    w.rect_span_y = rrf_pkg::COORD_W'(sy);
    w.paint_code  = rrf_pkg::CODE_W'(code);
    return w;
  endfunction

  function automatic rrf_pkg::rrf_in_t read_word(int unsigned col, int unsigned row);
    rrf_pkg::rrf_in_t w;
    w          = noise_word();
    w.cmd      = rrf_pkg::CMD_READ;
    w.read_col = rrf_pkg::SIDE_W'(col);
    w.read_row = rrf_pkg::SIDE_W'(row);
    return w;
  endfunction

  task automatic queue_clear();
    rrf_pkg::rrf_in_t w;
    w     = noise_word();
    w.cmd = rrf_pkg::CMD_CLEAR;
    pending_words.push_back(w);
  endtask

  // starts with a clear so that every pixel of the zone holds a known code
  task automatic queue_random(int n);
    int unsigned      zw, zh, pick;
    rrf_pkg::rrf_in_t w;
    zw = (zone_w_q > rrf_pkg::MAX_SIDE) ? rrf_pkg::MAX_SIDE : zone_w_q;
    zh = (zone_h_q > rrf_pkg::MAX_SIDE) ? rrf_pkg::MAX_SIDE : zone_h_q;
    queue_clear();
    repeat (n) begin
      pick = $urandom_range(0, 99);
      w    = noise_word();
      if (pick < 60) begin
        w.cmd         = (pick < 35) ? rrf_pkg::CMD_FILL : rrf_pkg::CMD_OUTLINE;
        w.rect_left   = rrf_pkg::COORD_W'(int'($urandom_range(0, (zw + 3) * 256)) - 512);
        w.rect_top    = rrf_pkg::COORD_W'(int'($urandom_range(0, (zh + 3) * 256)) - 512);
        w.rect_span_x = rrf_pkg::COORD_W'($urandom_range(1, (zw + 2) * 256));
        w.rect_span_y = rrf_pkg::COORD_W'($urandom_range(1, (zh + 2) * 256));
      end else if (pick < 80 && zw != 0 && zh != 0) begin
        w.cmd      = rrf_pkg::CMD_READ;
        w.read_col = rrf_pkg::SIDE_W'($urandom_range(0, zw - 1));
        w.read_row = rrf_pkg::SIDE_W'($urandom_range(0, zh - 1));
      end else if (pick < 85) begin
        w.cmd = rrf_pkg::CMD_READ;
      end else if (pick < 89) begin
        w.cmd = rrf_pkg::CMD_CLEAR;
      end else if (pick < 95) begin
        w.cmd = $urandom_range(0, 1) ? rrf_pkg::CMD_FILL : rrf_pkg::CMD_OUTLINE;
        if ($urandom_range(0, 1)) begin
          w.rect_span_x = rrf_pkg::COORD_W'(-int'($urandom_range(0, 524288)));
        end else begin
          w.rect_span_y = rrf_pkg::COORD_W'(-int'($urandom_range(0, 524288)));
        end
      end else begin
        w.cmd = $urandom_range(0, 1) ? rrf_pkg::CMD_FILL : rrf_pkg::CMD_OUTLINE;
      end
      pending_words.push_back(w);
    end
  endtask

  task automatic drain_all();
    while (pending_words.size() != 0 || in_valid_i || expected_words.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic write_reg(rrf_pkg::rrf_cfg_e idx, int unsigned val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= rrf_pkg::CFG_DAT_W'(val);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      rrf_pkg::CFG_ZONE_WIDTH:  zone_w_q = rrf_pkg::ZONE_W'(val);
      rrf_pkg::CFG_ZONE_HEIGHT: zone_h_q = rrf_pkg::ZONE_W'(val);
      rrf_pkg::CFG_BG_CODE:     bg_q     = rrf_pkg::CODE_W'(val);
      default: ;
    endcase
  endtask

  task automatic set_zone(int unsigned zw, int unsigned zh, int unsigned bg);
    drain_all();
    write_reg(rrf_pkg::CFG_ZONE_WIDTH, zw);
    write_reg(rrf_pkg::CFG_ZONE_HEIGHT, zh);
    write_reg(rrf_pkg::CFG_BG_CODE, bg);
  endtask

  // word driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_hold  <= 0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (in_valid_i) begin
        expected_words.push_back(paint_and_report(in_word_i));
      end
      if (send_hold != 0) begin
        send_hold  <= send_hold - 1;
        in_valid_i <= 1'b0;
      end else if (pending_words.size() != 0) begin
        in_word_i  <= pending_words.pop_front();
        in_valid_i <= 1'b1;
        send_hold  <= pick_gap(send_quiet);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      recv_hold   <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected: pixel_code %0d status %0d",
                 out_word_o.pixel_code, out_word_o.status);
          mismatch_count++;
        end else begin
          want_word = expected_words.pop_front();
          if (out_word_o.pixel_code !== want_word.pixel_code) begin
            $error("pixel_code expected %0d actual %0d",
                   want_word.pixel_code, out_word_o.pixel_code);
            mismatch_count++;
          end
          if (out_word_o.status !== want_word.status) begin
            $error("status expected %0d actual %0d", want_word.status, out_word_o.status);
            mismatch_count++;
          end
        end
      end
      if (recv_hold != 0) begin
        recv_hold   <= recv_hold - 1;
        out_stall_i <= 1'b1;
      end else begin
        recv_pick    = pick_gap(recv_quiet);
        out_stall_i <= (recv_pick != 0);
        recv_hold   <= (recv_pick != 0) ? recv_pick - 1 : 0;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("rectangle_raster_fill_tb NOT OK");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    idle_cycles    = 0;
    mismatch_count = 0;
    send_quiet     = 0;
    recv_quiet     = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset zone of one pixel
    queue_clear();
    pending_words.push_back(read_word(0, 0));
    pending_words.push_back(read_word(255, 255));

    set_zone(5, 4, 0);
    queue_clear();
    pending_words.push_back(shape_word(rrf_pkg::CMD_FILL, 'h080, 0, 'h200, 'h100, 'h11));
    pending_words.push_back(shape_word(rrf_pkg::CMD_OUTLINE, 0, 0, 4 << 8, 3 << 8, 'hff));
    pending_words.push_back(shape_word(rrf_pkg::CMD_OUTLINE, 'h100, 'h100, 'h100, 'h100,
                                       'h80));
    pending_words.push_back(shape_word(rrf_pkg::CMD_OUTLINE, 'h0ff, 1, 'h202, 'h201, 'h42));
    pending_words.push_back(shape_word(rrf_pkg::CMD_FILL, 0, 0, 0, 'h100, 'h01));
    pending_words.push_back(shape_word(rrf_pkg::CMD_OUTLINE, 0, 0, 'h100, -1, 'h02));
    pending_words.push_back(shape_word(rrf_pkg::CMD_FILL, 0, 0, -524288, 524287, 'h03));
    pending_words.push_back(shape_word(rrf_pkg::CMD_FILL, -524288, -524288, 524287, 524287,
                                       'h04));
    pending_words.push_back(shape_word(rrf_pkg::CMD_FILL, 524287, 524287, 524287, 524287,
                                       'h05));
    pending_words.push_back(shape_word(rrf_pkg::CMD_OUTLINE, -512, -512, 'h900, 'h800,
                                       'h7f));
    pending_words.push_back(read_word(0, 0));
    pending_words.push_back(read_word(2, 1));
    pending_words.push_back(read_word(3, 2));
    pending_words.push_back(read_word(4, 3));
    pending_words.push_back(read_word(5, 0));
    pending_words.push_back(read_word(0, 4));
    pending_words.push_back(shape_word(rrf_pkg::CMD_FILL, -1024, -1024, 524287, 524287,
                                       'h00));
    pending_words.push_back(read_word(1, 2));

    // oversized width, then an empty zone
    set_zone(300, 2, 255);
    queue_random(10);
    set_zone(0, 511, 'h5a);
    queue_random(6);

    // full-size zone, kept short since each scan walks every pixel
    set_zone(256, 256, 0);
    queue_clear();
    pending_words.push_back(shape_word(rrf_pkg::CMD_OUTLINE, -128, -128, 256 << 8, 200 << 8,
                                       'h3c));
    pending_words.push_back(shape_word(rrf_pkg::CMD_FILL, 'h2080, 'h3000, 'h4000, 'h1000,
                                       'hc3));
    pending_words.push_back(read_word(255, 255));
    pending_words.push_back(read_word(0, 0));
    pending_words.push_back(read_word(128, 200));
    pending_words.push_back(read_word(255, 0));
    pending_words.push_back(read_word(40, 60));

    set_zone(1, 1, $urandom_range(0, 255));
    queue_random(20);
    set_zone($urandom_range(2, 16), $urandom_range(2, 16), $urandom_range(0, 255));
    queue_random(20);
    set_zone($urandom_range(2, 16), $urandom_range(2, 16), $urandom_range(0, 255));
    queue_random(20);

    drain_all();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("rectangle_raster_fill_tb OK");
    end else begin
      $display("rectangle_raster_fill_tb NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
